@@ rtl/core/dfrd_pkg.sv @@
// Package for the display frame receive and decode block.
// Holds the frame geometry, the decode constants and the types shared by
// the decode logic and the top level. Depends on nothing.
`default_nettype none

package dfrd_pkg;

   localparam int FRAME_LEN = 13;
   localparam int COUNT_W   = $clog2(FRAME_LEN);

   localparam logic [7:0]  END_MARK    = 8'h0E;
   localparam logic [15:0] MASK_RESET  = 16'h47FE;
   localparam logic [6:0]  SPEED_BASE  = 7'd10;
   localparam logic [2:0]  WALK_LEVEL  = 3'd6;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      logic       frame_ok;
      logic       light_on;
      logic [2:0] assist_level;
      logic       walk_mode;
      logic [6:0] max_speed;
      logic [4:0] wheel_size;
      logic [7:0] pas_p1;
      logic [4:0] p_bits;
      logic [7:0] p5;
      logic [5:0] c1_c2_bits;
      logic [8:0] c4_c14_c5;
      logic [6:0] c13_c12;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/dfrd_decode.sv @@
// Frame check and field decode for the display frame receiver.
// Purely combinational; uses the frame and result types of dfrd_pkg.
`default_nettype none

module dfrd_decode (
   input  wire dfrd_pkg::frame_type frame,
   input  wire logic [15:0]         accept_mask,
   output dfrd_pkg::rsp_type        result
);
   import dfrd_pkg::*;

   logic [7:0] check_value;
   logic       check_ok;
   logic [5:0] speed_code;

   // The XOR of every byte but the check byte, XORed with the check byte,
   // is the XOR of the whole frame.
   always_comb begin
      check_value = '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
         check_value = check_value ^ frame[i];
      end
   end

   assign check_ok   = (check_value[7:4] == 4'd0) && accept_mask[check_value[3:0]];
   assign speed_code = {frame[4][5], frame[2][7:3]};

   always_comb begin
      result = '0;
      if (check_ok) begin
         result.frame_ok     = 1'b1;
         result.light_on     = frame[1][7];
         result.assist_level = frame[1][2:0];
         result.walk_mode    = (frame[1][2:0] == WALK_LEVEL);
         result.max_speed    = SPEED_BASE + {1'b0, speed_code};
         result.wheel_size   = {frame[2][2:0], frame[4][7:6]};
         result.pas_p1       = frame[3];
         result.p_bits       = frame[4][4:0];
         result.p5           = frame[0];
         result.c1_c2_bits   = frame[6][5:0];
         result.c4_c14_c5    = {frame[8][7:5], frame[7][6:5], frame[7][3:0]};
         result.c13_c12      = {frame[10][4:2], frame[9][3:0]};
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/display_frame_receive_decode_top.sv @@
// Top level of the display frame receiver: frame store, byte counter,
// end-of-frame pending flag and result register. Uses dfrd_pkg and dfrd_decode.
//
// Usage: each request on the req_ channel carries one received byte. The
// byte is written into a 13-byte frame store at the current position. A
// frame ends after 13 bytes or at a 0x0E byte; the store is not cleared,
// so a short frame reuses older bytes at the positions it did not reach.
// At a frame end one result is produced on the rsp_ channel, with frame_ok
// set when the XOR over the frame has a zero upper nibble and its low
// nibble selects a set bit of the accept mask. The final byte sets the
// pending flag, from which the result register is loaded once it is free.
// Throughput is one request per cycle while req_stall is low; the only
// limit is the single result register. When the receiver stalls rsp_,
// requests are still taken until a finished frame waits as pending behind
// the full result register; requests are then stalled until the result is
// taken. The csr_ port writes the accept mask and must only be used while
// the block is idle. Synchronous reset clears the frame store and the
// counter, empties the result register and loads the mask with 0x47FE.
`default_nettype none

module display_frame_receive_decode_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_frame_ok,
   output logic             rsp_light_on,
   output logic [2:0]       rsp_assist_level,
   output logic             rsp_walk_mode,
   output logic [6:0]       rsp_max_speed,
   output logic [4:0]       rsp_wheel_size,
   output logic [7:0]       rsp_pas_p1,
   output logic [4:0]       rsp_p_bits,
   output logic [7:0]       rsp_p5,
   output logic [5:0]       rsp_c1_c2_bits,
   output logic [8:0]       rsp_c4_c14_c5,
   output logic [6:0]       rsp_c13_c12
);
   import dfrd_pkg::*;

   frame_type          frame_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        mask_ff;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            decoded;
   logic               req_take;
   logic               frame_end;
   logic               rsp_free;

   dfrd_decode u_decode (
      .frame       (frame_ff),
      .accept_mask (mask_ff),
      .result      (decoded)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;
   assign frame_end = (count_ff == COUNT_W'(FRAME_LEN - 1)) || (req_rx_byte == END_MARK);

   always_comb begin
      count_in = count_ff;
      if (req_take) begin
         count_in = frame_end ? '0 : count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (pend_ff && rsp_free) begin
         pend_in = 1'b0;
      end
      if (req_take && frame_end) begin
         pend_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         count_ff     <= '0;
         mask_ff      <= MASK_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            frame_ff[count_ff] <= req_rx_byte;
         end
         if (csr_write_enable) begin
            mask_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && rsp_free) begin
         rsp_ff <= decoded;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ok     = rsp_ff.frame_ok;
   assign rsp_light_on     = rsp_ff.light_on;
   assign rsp_assist_level = rsp_ff.assist_level;
   assign rsp_walk_mode    = rsp_ff.walk_mode;
   assign rsp_max_speed    = rsp_ff.max_speed;
   assign rsp_wheel_size   = rsp_ff.wheel_size;
   assign rsp_pas_p1       = rsp_ff.pas_p1;
   assign rsp_p_bits       = rsp_ff.p_bits;
   assign rsp_p5           = rsp_ff.p5;
   assign rsp_c1_c2_bits   = rsp_ff.c1_c2_bits;
   assign rsp_c4_c14_c5    = rsp_ff.c4_c14_c5;
   assign rsp_c13_c12      = rsp_ff.c13_c12;

   // The store position always stays inside the frame.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < COUNT_W'(FRAME_LEN))
      else $error("frame position out of range");

   // A byte that ends a frame leaves a pending frame behind it.
   a_end_pends: assert property (@(posedge clock) disable iff (reset)
      (req_take && frame_end) |=> pend_ff)
      else $error("frame end did not set the pending flag");

   // A new result only ever comes from a pending frame.
   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff))
      else $error("result appeared without a pending frame");

   // A rejected frame carries all-zero fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.frame_ok) |-> (rsp_ff == '0))
      else $error("rejected frame has nonzero fields");

endmodule

`default_nettype wire
